[rtl/rle_delta_frame_decoder_top_defines.svh]
// rle_delta_frame_decoder_top_defines.svh
// Assertion macros for the frame decoder top level; no dependencies.
// Expects clk and arst_n in the scope of use.
`ifndef RLE_DELTA_FRAME_DECODER_TOP_DEFINES_SVH
`define RLE_DELTA_FRAME_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RDFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdfd check failed");
`define RDFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdfd check failed");
`else
`define RDFD_ASSERT_IMP(lbl, ante, cons)
`define RDFD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/rdfd_pkg.sv]
// rdfd_pkg.sv
// Shared constants and types of the RLE delta frame decoder; no dependencies.
package rdfd_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 255;
	localparam int MAX_RESULTS  = 64;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

	// result kinds
	localparam logic [1:0] KIND_RECT = 2'd0;
	localparam logic [1:0] KIND_SEG  = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	// header type, bits 7..6
	localparam logic [1:0] TYPE_RAW   = 2'd0;
	localparam logic [1:0] TYPE_DELTA = 2'd2;

	// run colors
	localparam logic [1:0] CLR_BG = 2'd0;
	localparam logic [1:0] CLR_FG = 2'd1;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_POS_X  = 3'd2;
	localparam logic [2:0] REG_POS_Y  = 3'd3;
	localparam logic [2:0] REG_FG     = 3'd4;
	localparam logic [2:0] REG_BG     = 3'd5;

	typedef struct packed {
		logic [7:0]  width;
		logic [6:0]  height;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] fg;
		logic [15:0] bg;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  len;
		logic [6:0]  rows;
		logic [15:0] color;
		logic        last;
		logic        done;
		logic        bad;
	} res_t;

endpackage

[rtl/rle_delta_frame_decoder_top.sv]
// rle_delta_frame_decoder_top.sv
// Top level: configuration registers, sequencer and output register.
// Uses rdfd_pkg, rdfd_seq, rdfd_out_buf and rle_delta_frame_decoder_top_defines.svh.
//
// Takes one compressed byte per input word and returns one or more draw words, the
// final one marked by last. One byte is in work at a time: a header byte or a byte
// that draws nothing goes through decode and flush; a byte that draws also waits on
// the shared one-bit-per-cycle divider (pixel index into row and column, 14 quotient
// bits at the default size) and steps a run by segments or a literal by bits, then
// flushes. A stalled result side holds the stepping and the flush. At most 64 words
// come out of one byte; the last result waits in the output register while the next
// byte is taken. Configuration writes are always accepted; the user must make them
// between bytes to take effect on the next byte, which the block does not enforce.
`include "rle_delta_frame_decoder_top_defines.svh"
module rle_delta_frame_decoder_top #(
	parameter int MAX_ROWS = rdfd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rdfd_pkg::MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [15:0] seg_x,
	output logic signed [15:0] seg_y,
	output logic [7:0]         seg_length,
	output logic [6:0]         seg_rows,
	output logic [15:0]        seg_color,
	output logic               last,
	output logic               frame_done,
	output logic               bad_type
);
	import rdfd_pkg::*;

	cfg_t cfg_q;
	res_t push_word;
	res_t out_word;
	logic push;
	logic can_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 8'd1;
			cfg_q.height <= 7'd1;
			cfg_q.pos_x  <= 16'd0;
			cfg_q.pos_y  <= 16'd0;
			cfg_q.fg     <= 16'hFFFF;
			cfg_q.bg     <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data[7:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[6:0];
				REG_POS_X:  cfg_q.pos_x  <= cfg_data;
				REG_POS_Y:  cfg_q.pos_y  <= cfg_data;
				REG_FG:     cfg_q.fg     <= cfg_data;
				REG_BG:     cfg_q.bg     <= cfg_data;
				default:    ;
			endcase
		end
	end

	rdfd_seq #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.push        (push),
		.push_word   (push_word),
		.can_push    (can_push)
	);

	rdfd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.word      (push_word),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign kind       = out_word.kind;
	assign seg_x      = out_word.x;
	assign seg_y      = out_word.y;
	assign seg_length = out_word.len;
	assign seg_rows   = out_word.rows;
	assign seg_color  = out_word.color;
	assign last       = out_word.last;
	assign frame_done = out_word.done;
	assign bad_type   = out_word.bad;

	`RDFD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`RDFD_ASSERT_IMP(a_none_is_zero, out_valid && (kind == KIND_NONE), (seg_x == 16'sd0) && (seg_y == 16'sd0) && (seg_length == 8'd0) && (seg_rows == 7'd0) && (seg_color == 16'd0))
	`RDFD_ASSERT_IMP(a_bad_alone, out_valid && bad_type, (kind == KIND_NONE) && last && !frame_done)
	`RDFD_ASSERT_IMP(a_seg_shape, out_valid && (kind == KIND_SEG), (seg_rows == 7'd1) && (seg_length != 8'd0))

endmodule

[rtl/rdfd_divider.sv]
// rdfd_divider.sv
// Restoring divider, one quotient bit per cycle: pixel index by frame width.
// Standalone, no package use.
module rdfd_divider #(
	parameter int DW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [7:0]    divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [7:0]    rem
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] quo_q;
	logic [7:0]    rem_q;
	logic [7:0]    dsr_q;
	logic [8:0]    trial;
	logic          take;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		take  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 8'd0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
			quo_q <= DW'({quo_q, take});
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/rdfd_out_buf.sv]
// rdfd_out_buf.sv
// One-word output register between the sequencer and the result channel.
// Uses rdfd_pkg for the result word type.
module rdfd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rdfd_pkg::res_t word,
	output logic          can_push,
	output logic          out_valid,
	input  logic          out_ready,
	output rdfd_pkg::res_t out_word
);
	import rdfd_pkg::*;

	logic full_q;
	res_t word_q;

	assign can_push  = !full_q || out_ready;
	assign out_valid = full_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (out_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= word;
		end
	end

endmodule

[rtl/rdfd_seq.sv]
// rdfd_seq.sv
// Byte decoder and segment sequencer: frame state, run/literal stepping.
// Uses rdfd_pkg and rdfd_divider.
module rdfd_seq #(
	parameter int MAX_ROWS = rdfd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rdfd_pkg::MAX_COLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rdfd_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           frame_start,
	output logic           push,
	output rdfd_pkg::res_t push_word,
	input  logic           can_push
);
	import rdfd_pkg::*;

	localparam int HMAX = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int TMAX = MAX_COLS * HMAX;
	localparam int PW   = $clog2(TMAX + 1);
	localparam int HW   = $clog2(HMAX + 1);
	localparam int PRW  = 8 + HW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_LIT   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]       st_q;
	logic [7:0]       data_q;
	logic             start_q;

	// frame state
	logic             active_q, delta_q, pend_q, lit_q;
	logic [1:0]       prev_q, rcolor_q;
	logic [PW-1:0]    pos_q;
	logic [15:0]      acc_q;

	// working registers of one byte
	logic [PW-1:0]    idx_q, row_q;
	logic [7:0]       col_q;
	logic [15:0]      len_q;
	logic [6:0]       bits_q;
	logic [2:0]       k_q;
	logic [15:0]      color_q;
	logic             draw_lit_q;
	res_t             stg_q;
	logic             stg_v_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q, bad_q;

	logic [7:0]       w;
	logic [HW-1:0]    h;
	logic [PRW-1:0]   prod;
	logic [PW-1:0]    total;

	logic [2:0]       csum;
	logic [1:0]       rc_d, rc_run;
	logic [15:0]      acc_run;
	logic             fin_run, draw_run;
	logic             lit_nx, pend_nx;
	logic [1:0]       prev_nx;
	logic [15:0]      add_nx;
	logic [16:0]      psum;
	logic [PW-1:0]    pos_nx;
	logic             done_nx;

	logic [7:0]       col_room, seg1, seg, col_inc;
	logic [PW-1:0]    tot_room;
	logic             run_more, wrap, cap, stall;
	logic             run_go, lit_go, lit_end, lit_bit, lit_in, lit_want;
	res_t             rect_word, seg_word, none_word;

	logic             div_start, div_done;
	logic [PW-1:0]    div_quot;
	logic [7:0]       div_rem;

	// clamped frame geometry
	always_comb begin
		w     = (cfg.width > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cfg.width;
		h     = (32'(cfg.height) > 32'(MAX_ROWS)) ? HW'(HMAX) : HW'(cfg.height);
		prod  = PRW'(w) * PRW'(h);
		total = PW'(prod);
	end

	// data byte decode
	always_comb begin
		csum = 3'(prev_q) + 3'd1 + 3'(data_q[6]);
		case (csum)
			3'd3:    rc_d = 2'd0;
			3'd4:    rc_d = 2'd1;
			3'd5:    rc_d = 2'd2;
			default: rc_d = csum[1:0];
		endcase

		if (pend_q) begin
			acc_run = {acc_q[8:0], data_q[6:0]};
			rc_run  = rcolor_q;
		end else if (delta_q) begin
			acc_run = {10'd0, data_q[5:0]};
			rc_run  = rc_d;
		end else begin
			acc_run = {9'd0, data_q[6:0]};
			rc_run  = 2'd1 - prev_q;
		end
		fin_run  = !data_q[7];
		draw_run = fin_run && (acc_run != 16'd0)
			&& ((rc_run == CLR_FG) || (delta_q && (rc_run == CLR_BG)));

		if (lit_q) begin
			lit_nx  = data_q[7];
			pend_nx = 1'b0;
			prev_nx = {1'b0, data_q[0]};
			add_nx  = 16'd7;
		end else begin
			lit_nx  = fin_run && (acc_run == 16'd0);
			pend_nx = data_q[7];
			prev_nx = (fin_run && (acc_run != 16'd0)) ? rc_run : prev_q;
			add_nx  = fin_run ? acc_run : 16'd0;
		end

		psum = 17'(pos_q) + 17'(add_nx);
		if (pos_q < total) begin
			pos_nx = (psum > 17'(total)) ? total : PW'(psum);
		end else begin
			pos_nx = pos_q;
		end
		done_nx = !lit_nx && !pend_nx && (pos_nx >= total);
	end

	// segment and literal stepping
	always_comb begin
		cap      = (cnt_q == CNT_W'(MAX_RESULTS));
		stall    = stg_v_q && !can_push;
		col_room = w - col_q;
		tot_room = total - idx_q;
		seg1     = (16'(col_room) < len_q) ? col_room : len_q[7:0];
		seg      = (16'(seg1) > 16'(tot_room)) ? 8'(tot_room) : seg1;
		run_more = (len_q != 16'd0) && (idx_q < total);
		wrap     = (seg == col_room);
		run_go   = (st_q == ST_RUN) && run_more && !cap && !stall;

		col_inc  = col_q + 8'd1;
		lit_bit  = bits_q[6];
		lit_in   = (idx_q < total);
		lit_want = (lit_bit || delta_q) && lit_in;
		lit_end  = (k_q == 3'd7) || cap;
		lit_go   = (st_q == ST_LIT) && !lit_end && !(lit_want && stall);
	end

	always_comb begin
		rect_word       = '0;
		rect_word.kind  = KIND_RECT;
		rect_word.x     = cfg.pos_x;
		rect_word.y     = cfg.pos_y;
		rect_word.len   = w;
		rect_word.rows  = 7'(h);
		rect_word.color = cfg.bg;

		seg_word       = '0;
		seg_word.kind  = KIND_SEG;
		seg_word.x     = cfg.pos_x + 16'(col_q);
		seg_word.y     = cfg.pos_y + 16'(row_q);
		seg_word.rows  = 7'd1;
		if (st_q == ST_LIT) begin
			seg_word.len   = 8'd1;
			seg_word.color = lit_bit ? cfg.fg : cfg.bg;
		end else begin
			seg_word.len   = seg;
			seg_word.color = color_q;
		end

		none_word      = '0;
		none_word.kind = KIND_NONE;

		push_word      = stg_v_q ? stg_q : none_word;
		push_word.last = (st_q == ST_FLUSH);
		push_word.done = done_q;
		push_word.bad  = bad_q;

		case (st_q)
			ST_RUN:   push = run_go && stg_v_q;
			ST_LIT:   push = lit_go && lit_want && stg_v_q;
			ST_FLUSH: push = can_push;
			default:  push = 1'b0;
		endcase
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign div_start = (st_q == ST_DEC) && !start_q && active_q && (lit_q || draw_run);

	rdfd_divider #(
		.DW(PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pos_q),
		.divisor  (w),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			active_q <= 1'b0;
			delta_q  <= 1'b0;
			prev_q   <= 2'd0;
			pos_q    <= '0;
			acc_q    <= 16'd0;
			pend_q   <= 1'b0;
			rcolor_q <= 2'd0;
			lit_q    <= 1'b0;
			stg_v_q  <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			bad_q    <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					cnt_q   <= '0;
					stg_v_q <= 1'b0;
					done_q  <= 1'b0;
					bad_q   <= 1'b0;
					st_q    <= ST_FLUSH;
					if (start_q) begin
						pend_q <= 1'b0;
						lit_q  <= 1'b0;
						acc_q  <= 16'd0;
						pos_q  <= '0;
						if (data_q[7:6] == TYPE_RAW) begin
							active_q <= 1'b0;
							bad_q    <= 1'b1;
						end else begin
							active_q <= (total != '0);
							done_q   <= (total == '0);
							delta_q  <= (data_q[7:6] == TYPE_DELTA);
							prev_q   <= data_q[1:0];
							if (data_q[7:6] != TYPE_DELTA) begin
								stg_v_q <= 1'b1;
								cnt_q   <= CNT_W'(1);
							end
						end
					end else if (active_q) begin
						lit_q    <= lit_nx;
						pend_q   <= pend_nx;
						prev_q   <= prev_nx;
						pos_q    <= pos_nx;
						active_q <= !done_nx;
						done_q   <= done_nx;
						if (!lit_q) begin
							acc_q    <= acc_run;
							rcolor_q <= rc_run;
						end
						if (lit_q || draw_run) begin
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= draw_lit_q ? ST_LIT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!run_more || cap) begin
						st_q <= ST_FLUSH;
					end else if (!stall) begin
						stg_v_q <= 1'b1;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				ST_LIT: begin
					if (lit_end) begin
						st_q <= ST_FLUSH;
					end else if (lit_go && lit_want) begin
						stg_v_q <= 1'b1;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				ST_FLUSH: begin
					if (can_push) begin
						stg_v_q <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q  <= data_byte;
			start_q <= frame_start;
		end
		if (st_q == ST_DEC) begin
			idx_q      <= pos_q;
			len_q      <= acc_run;
			bits_q     <= data_q[6:0];
			k_q        <= 3'd0;
			draw_lit_q <= lit_q;
			color_q    <= (rc_run == CLR_FG) ? cfg.fg : cfg.bg;
			stg_q      <= rect_word;
		end
		if ((st_q == ST_DIV) && div_done) begin
			row_q <= div_quot;
			col_q <= div_rem;
		end
		if (run_go) begin
			stg_q <= seg_word;
			idx_q <= idx_q + PW'(seg);
			len_q <= len_q - 16'(seg);
			if (wrap) begin
				col_q <= 8'd0;
				row_q <= row_q + PW'(1);
			end else begin
				col_q <= col_q + seg;
			end
		end
		if (lit_go) begin
			if (lit_want) begin
				stg_q <= seg_word;
			end
			if (lit_in) begin
				idx_q <= idx_q + PW'(1);
				if (col_inc == w) begin
					col_q <= 8'd0;
					row_q <= row_q + PW'(1);
				end else begin
					col_q <= col_inc;
				end
			end
			bits_q <= {bits_q[5:0], 1'b0};
			k_q    <= k_q + 3'd1;
		end
	end

endmodule

[verif/tb_rle_delta_frame_decoder_top.sv]
`timescale 1ns / 1ps
// tb_rle_delta_frame_decoder_top.sv
// Self-checking bench for rle_delta_frame_decoder_top: drives compressed frames, predicts
// the draw words in a scoreboard class and compares them. Depends on rdfd_pkg and the RTL.
module tb_rle_delta_frame_decoder_top;
	import rdfd_pkg::*;

	class draw_scoreboard;
		logic [7:0]  width_q;
		logic [6:0]  height_q;
		logic [15:0] pos_x_q;
		logic [15:0] pos_y_q;
		logic [15:0] fg_q;
		logic [15:0] bg_q;
		bit          active;
		bit          delta_mode;
		bit          run_pending;
		bit          in_literal;
		logic [1:0]  prev_color;
		logic [1:0]  run_color;
		logic [15:0] run_accum;
		int unsigned pixel_pos;
		res_t        expected_draws[$];
		res_t        byte_draws[$];
		int          errors;

		function new();
			width_q = 8'd1;
			height_q = 7'd1;
			pos_x_q = '0;
			pos_y_q = '0;
			fg_q = 16'hFFFF;
			bg_q = '0;
			active = 0;
			delta_mode = 0;
			run_pending = 0;
			in_literal = 0;
			prev_color = CLR_BG;
			run_color = CLR_BG;
			run_accum = '0;
			pixel_pos = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_WIDTH:  width_q = val[7:0];
				REG_HEIGHT: height_q = val[6:0];
				REG_POS_X:  pos_x_q = val;
				REG_POS_Y:  pos_y_q = val;
				REG_FG:     fg_q = val;
				REG_BG:     bg_q = val;
				default: ;
			endcase
		endfunction

		// words past the per-byte cap are dropped
		function void push_draw(logic [1:0] k, int unsigned col, int unsigned row,
				int unsigned len, int unsigned rows, logic [15:0] color);
			res_t d;
			if (byte_draws.size() >= MAX_RESULTS)
				return;
			d = '0;
			d.kind = k;
			d.x = pos_x_q + 16'(col);
			d.y = pos_y_q + 16'(row);
			d.len = 8'(len);
			d.rows = 7'(rows);
			d.color = color;
			byte_draws.push_back(d);
		endfunction

		function void draw_run(int unsigned w, int unsigned total, int unsigned len,
				logic [15:0] color);
			int unsigned idx, col, row, seg, rem;
			idx = pixel_pos;
			rem = len;
			while (rem > 0 && idx < total && w > 0) begin
				col = idx % w;
				row = idx / w;
				seg = w - col;
				if (seg > rem)
					seg = rem;
				if (seg > total - idx)
					seg = total - idx;
				push_draw(KIND_SEG, col, row, seg, 1, color);
				idx += seg;
				rem -= seg;
			end
		endfunction

		function void close_run(int unsigned w, int unsigned total);
			int unsigned len;
			len = 32'(run_accum);
			run_pending = 0;
			if (len == 0) begin
				in_literal = 1;
				return;
			end
			if (run_color == CLR_FG)
				draw_run(w, total, len, fg_q);
			else if (delta_mode && run_color == CLR_BG)
				draw_run(w, total, len, bg_q);
			prev_color = run_color;
			if (pixel_pos < total)
				pixel_pos = (pixel_pos + len > total) ? total : pixel_pos + len;
		endfunction

		// one accepted word: update state, queue the draw words it causes
		function void byte_accepted(logic [7:0] data, logic start);
			int unsigned w, h, total;
			bit done, bad, px;
			logic [7:0] bits;
			res_t d;
			w = (width_q > MAX_COLS_DEF) ? MAX_COLS_DEF : width_q;
			h = (height_q > MAX_ROWS_DEF) ? MAX_ROWS_DEF : height_q;
			total = w * h;
			done = 0;
			bad = 0;
			byte_draws.delete();
			if (start) begin
				run_pending = 0;
				in_literal = 0;
				run_accum = '0;
				pixel_pos = 0;
				if (data[7:6] == TYPE_RAW) begin
					active = 0;
					bad = 1;
				end else begin
					active = 1;
					delta_mode = (data[7:6] == TYPE_DELTA);
					prev_color = data[1:0];
					if (!delta_mode)
						push_draw(KIND_RECT, 0, 0, w, h, bg_q);
					if (total == 0) begin
						active = 0;
						done = 1;
					end
				end
			end else if (active) begin
				if (in_literal) begin
					bits = data;
					px = 0;
					for (int k = 0; k < 7; k++) begin
						px = bits[6];
						if ((px || delta_mode) && pixel_pos < total)
							push_draw(KIND_SEG, pixel_pos % w, pixel_pos / w, 1, 1,
								px ? fg_q : bg_q);
						if (pixel_pos < total)
							pixel_pos++;
						bits = bits << 1;
					end
					prev_color = px ? CLR_FG : CLR_BG;
					if (!data[7])
						in_literal = 0;
				end else if (run_pending) begin
					run_accum = {run_accum[8:0], data[6:0]};
					if (!data[7])
						close_run(w, total);
				end else begin
					if (delta_mode) begin
						run_color = 2'((int'(prev_color) + 1 + int'(data[6])) % 3);
						run_accum = {10'd0, data[5:0]};
					end else begin
						run_color = 2'd1 - prev_color;
						run_accum = {9'd0, data[6:0]};
					end
					if (data[7])
						run_pending = 1;
					else
						close_run(w, total);
				end
				if (!in_literal && !run_pending && pixel_pos >= total) begin
					active = 0;
					done = 1;
				end
			end
			if (byte_draws.size() == 0) begin
				d = '0;
				d.kind = KIND_NONE;
				byte_draws.push_back(d);
			end
			foreach (byte_draws[i]) begin
				d = byte_draws[i];
				d.last = (i == byte_draws.size() - 1);
				d.done = done;
				d.bad = bad;
				expected_draws.push_back(d);
			end
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				if (errors < 50)
					$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_draw(res_t got);
			res_t want;
			if (expected_draws.size() == 0) begin
				errors++;
				if (errors < 50)
					$display("%0t: draw word with none pending, expected none actual %h",
						$time, got);
				return;
			end
			want = expected_draws.pop_front();
			compare("kind", 16'(want.kind), 16'(got.kind));
			compare("seg_x", want.x, got.x);
			compare("seg_y", want.y, got.y);
			compare("seg_length", 16'(want.len), 16'(got.len));
			compare("seg_rows", 16'(want.rows), 16'(got.rows));
			compare("seg_color", want.color, got.color);
			compare("last", 16'(want.last), 16'(got.last));
			compare("frame_done", 16'(want.done), 16'(got.done));
			compare("bad_type", 16'(want.bad), 16'(got.bad));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_WIDTH;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] seg_x;
	logic [15:0] seg_y;
	logic [7:0]  seg_length;
	logic [6:0]  seg_rows;
	logic [15:0] seg_color;
	logic        last;
	logic        frame_done;
	logic        bad_type;

	draw_scoreboard sb = new();
	bit idling = 1'b0;
	int n_items = 0;
	int stall_left = 0;

	rle_delta_frame_decoder_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.seg_x      (seg_x),
		.seg_y      (seg_y),
		.seg_length (seg_length),
		.seg_rows   (seg_rows),
		.seg_color  (seg_color),
		.last       (last),
		.frame_done (frame_done),
		.bad_type   (bad_type)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side stalls at random in bursts while idling is set
	always @(posedge clk) begin
		if (!idling) begin
			out_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : draw_monitor
		res_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, seg_x, seg_y, seg_length, seg_rows, seg_color, last, frame_done,
				bad_type};
			sb.check_draw(got);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic s);
		if (idling && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		if (s || sb.active)
			n_items++;
		in_valid <= 1'b1;
		data_byte <= d;
		frame_start <= s;
		do @(posedge clk); while (!in_ready);
		sb.byte_accepted(d, s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_draws.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high between writes so it is never dropped and raised in one step
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_regs(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] fg, input logic [15:0] bg);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_POS_X, px);
		write_reg(REG_POS_Y, py);
		write_reg(REG_FG, fg);
		write_reg(REG_BG, bg);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame();
		logic [7:0] hdr;
		logic [7:0] b;
		int nbytes;
		int len;
		int cnt;
		hdr = 8'($urandom);
		case ($urandom_range(0, 2))
			0: hdr[7:6] = 2'b01;
			1: hdr[7:6] = TYPE_DELTA;
			default: hdr[7:6] = 2'b11;
		endcase
		if ($urandom_range(0, 3) == 0)
			hdr[7:6] = TYPE_DELTA;
		send_byte(hdr, 1'b1);
		nbytes = 0;
		while (sb.active && nbytes < 40) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(1, 12);
					b = 8'($urandom);
					if (sb.delta_mode)
						b[5:0] = 6'(len);
					else
						b[6:0] = 7'(len);
					b[7] = 1'b0;
					send_byte(b, 1'b0);
					nbytes++;
				end
				6, 7: begin
					send_byte(8'($urandom) | 8'h80, 1'b0);
					cnt = $urandom_range(1, 2);
					for (int i = 1; i < cnt; i++)
						send_byte(8'($urandom) | 8'h80, 1'b0);
					send_byte(8'($urandom) & 8'h7F, 1'b0);
					nbytes += cnt + 1;
				end
				8: begin
					// zero-length run in delta mode (in plain mode only when bit 6 is clear), then escaped pixel words
					b = '0;
					b[6] = 1'($urandom);
					send_byte(b, 1'b0);
					cnt = $urandom_range(1, 3);
					for (int i = 0; i < cnt; i++) begin
						b = 8'($urandom);
						b[7] = (i != cnt - 1);
						send_byte(b, 1'b0);
					end
					nbytes += cnt + 1;
				end
				default: begin
					send_byte(8'($urandom), 1'b0);
					nbytes++;
				end
			endcase
		end
	endtask

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [15:0] w, h;
		logic [7:0] hdr;
		int frames;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: outside a frame, raw type, ignored word
		idling = 1'b1;
		send_byte(8'h55, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		drain();

		// largest frame, corner positions, long wrapping run hits the word cap
		set_regs(16'd255, 16'd64, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
		send_byte(8'h40, 1'b1);
		send_byte(8'h85, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		// delta header mid frame, transparent, background, literal words
		send_byte(8'h83, 1'b1);
		send_byte(8'h45, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h41, 1'b0);
		// type 3 as plain, start color 2 never draws
		send_byte(8'hC2, 1'b1);
		send_byte(8'h05, 1'b0);
		send_byte(8'h05, 1'b0);
		// plain literal draws the ones only
		send_byte(8'h41, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
		drain();

		// tiny frame: literal clipped at the end and continued past it
		set_regs(16'd3, 16'd2, 16'hFFFF, 16'h7FFF, 16'h1234, 16'hFFFF);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h12, 1'b0);
		drain();

		// empty frame completes at the header
		set_regs(16'd5, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_byte(8'h40, 1'b1);
		send_byte(8'h80, 1'b1);

		n_items = 0;
		frames = 0;
		while (n_items < 210) begin
			if (frames % 3 == 0) begin
				drain();
				case ($urandom_range(0, 7))
					0: begin w = 16'd255; h = 16'd64; end
					1: begin w = 16'd1; h = 16'd1; end
					2: begin w = 16'($urandom_range(1, 8)); h = 16'd100; end
					default: begin
						w = 16'($urandom_range(1, 24));
						h = 16'($urandom_range(1, 6));
					end
				endcase
				set_regs(w, h, 16'($urandom), 16'($urandom),
					($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom),
					($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
			end
			idling = (n_items < 180) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom), 1'b0);
				1: begin
					hdr = 8'($urandom);
					hdr[7:6] = TYPE_RAW;
					send_byte(hdr, 1'b1);
				end
				default: ;
			endcase
			send_frame();
			frames++;
		end

		idling = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_draws.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
